[hw/rtl/ipsf_pkg.sv]
// Package for the I/Q pulse-shaping FIR: sample/coefficient types,
// register map constants and coefficient reset values.
// No dependencies.
package ipsf_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned PROD_W    = 2 * SAMPLE_W;
  localparam int unsigned NUM_COEF  = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned FRAC_W    = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SAMPLE_W-1:0] coef_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST = CFG_IDX_W'(NUM_COEF - 1);

  localparam coef_t COEF0_RESET = 16'sh7fff;
  localparam coef_t COEFN_RESET = 16'sh0000;

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

endpackage

[hw/rtl/iq_pulse_shaping_fir_core.sv]
// I/Q pulse-shaping FIR top: coefficient registers, sample history and a
// chain of TAPS multiply-accumulate cells ending in a round/saturate stage.
// A request passes the TAPS cell registers, then the round/saturate register.
// Throughput: one I/Q request per cycle unless stalled; each stage advances
// when empty or its successor moves, so bubbles collapse under output stall.
// Reset (async, active low): pipeline empty, history zero, coef_0 = 0x7fff.
module iq_pulse_shaping_fir_core #(
  parameter int unsigned TAPS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ipsf_pkg::sample_t                in_i_i,
  input  ipsf_pkg::sample_t                in_q_i,
  input  logic                             block_start_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ipsf_pkg::sample_t                out_i_o,
  output ipsf_pkg::sample_t                out_q_o,
  output logic                             saturated_o,
  input  logic                             cfg_we_i,
  input  logic [ipsf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ipsf_pkg::CFG_DAT_W-1:0]   cfg_data_i
);
  import ipsf_pkg::*;

  localparam int unsigned ACC_W  = PROD_W + $clog2(TAPS);
  localparam int unsigned HIST_N = (TAPS > 1) ? TAPS - 1 : 1;
  localparam int unsigned CIDX_W = $clog2(NUM_COEF);

  coef_t   coef_q [NUM_COEF];
  sample_t hist_i_q [HIST_N];
  sample_t hist_q_q [HIST_N];
  sample_t hist_i_d [HIST_N];
  sample_t hist_q_d [HIST_N];

  logic [TAPS:0]                       vld;
  logic [TAPS:0]                       rdy;
  logic [TAPS:0][TAPS-1:0][SAMPLE_W-1:0] win_i, win_q;
  logic [TAPS-1:0][SAMPLE_W-1:0]       win0_i, win0_q;
  logic signed [ACC_W-1:0]             acc_i [TAPS+1];
  logic signed [ACC_W-1:0]             acc_q [TAPS+1];
  logic                                accept;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        coef_q[k] <= (k == 0) ? COEF0_RESET : COEFN_RESET;
      end
    end else if (cfg_we_i && cfg_idx_i >= REG_COEF_0 && cfg_idx_i <= REG_COEF_LAST) begin
      coef_q[cfg_idx_i[CIDX_W-1:0]] <= $signed(cfg_data_i);
    end
  end

  // flow control through the chain; rdy[k] loads the register of cell k
  always_comb begin
    rdy[TAPS] = !out_valid_o || !out_stall_i;
    for (int k = TAPS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k+1] || rdy[k+1];
    end
  end

  assign vld[0]     = in_valid_i;
  assign in_stall_o = !rdy[0];
  assign accept     = in_valid_i && rdy[0];

  // sample window for the new request and history update
  always_comb begin
    win0_i    = '0;
    win0_q    = '0;
    win0_i[0] = in_i_i;
    win0_q[0] = in_q_i;
    for (int k = 1; k < TAPS; k++) begin
      win0_i[k] = block_start_i ? '0 : hist_i_q[k-1];
      win0_q[k] = block_start_i ? '0 : hist_q_q[k-1];
    end
    hist_i_d[0] = in_i_i;
    hist_q_d[0] = in_q_i;
    for (int k = 1; k < HIST_N; k++) begin
      hist_i_d[k] = block_start_i ? '0 : hist_i_q[k-1];
      hist_q_d[k] = block_start_i ? '0 : hist_q_q[k-1];
    end
  end

  assign win_i[0] = win0_i;
  assign win_q[0] = win0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HIST_N; k++) begin
        hist_i_q[k] <= '0;
        hist_q_q[k] <= '0;
      end
    end else if (accept) begin
      hist_i_q <= hist_i_d;
      hist_q_q <= hist_q_d;
    end
  end

  assign acc_i[0] = '0;
  assign acc_q[0] = '0;

  for (genvar g = 0; g < TAPS; g++) begin : g_tap
    ipsf_tap_cell #(
      .TAPS  (TAPS),
      .ACC_W (ACC_W),
      .IDX   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (rdy[g]),
      .valid_i (vld[g]),
      .coef_i  (coef_q[g]),
      .win_i_i (win_i[g]),
      .win_q_i (win_q[g]),
      .acc_i_i (acc_i[g]),
      .acc_q_i (acc_q[g]),
      .valid_o (vld[g+1]),
      .win_i_o (win_i[g+1]),
      .win_q_o (win_q[g+1]),
      .acc_i_o (acc_i[g+1]),
      .acc_q_o (acc_q[g+1])
    );
  end

  ipsf_round_sat #(
    .ACC_W (ACC_W)
  ) u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (rdy[TAPS]),
    .valid_i (vld[TAPS]),
    .acc_i_i (acc_i[TAPS]),
    .acc_q_i (acc_q[TAPS]),
    .valid_o (out_valid_o),
    .out_i_o (out_i_o),
    .out_q_o (out_q_o),
    .sat_o   (saturated_o)
  );

endmodule

[hw/rtl/ipsf_tap_cell.sv]
// One tap cell of the FIR chain: multiply-accumulate for I and Q and a
// register stage that passes the sample window and partial sums onward.
// Depends on ipsf_pkg.
module ipsf_tap_cell #(
  parameter int unsigned TAPS  = 8,
  parameter int unsigned ACC_W = 35,
  parameter int unsigned IDX   = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   load_i,
  input  logic                                   valid_i,
  input  ipsf_pkg::coef_t                        coef_i,
  input  logic [TAPS-1:0][ipsf_pkg::SAMPLE_W-1:0] win_i_i,
  input  logic [TAPS-1:0][ipsf_pkg::SAMPLE_W-1:0] win_q_i,
  input  logic signed [ACC_W-1:0]                acc_i_i,
  input  logic signed [ACC_W-1:0]                acc_q_i,
  output logic                                   valid_o,
  output logic [TAPS-1:0][ipsf_pkg::SAMPLE_W-1:0] win_i_o,
  output logic [TAPS-1:0][ipsf_pkg::SAMPLE_W-1:0] win_q_o,
  output logic signed [ACC_W-1:0]                acc_i_o,
  output logic signed [ACC_W-1:0]                acc_q_o
);
  import ipsf_pkg::*;

  logic signed [PROD_W-1:0] prod_i, prod_q;
  logic signed [ACC_W-1:0]  acc_i_d, acc_q_d;
  logic signed [ACC_W-1:0]  acc_i_q, acc_q_q;
  logic [TAPS-1:0][SAMPLE_W-1:0] win_i_q, win_q_q;
  logic valid_q;

  always_comb begin
    prod_i  = coef_i * $signed(win_i_i[IDX]);
    prod_q  = coef_i * $signed(win_q_i[IDX]);
    acc_i_d = acc_i_i + ACC_W'(prod_i);
    acc_q_d = acc_q_i + ACC_W'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      win_i_q <= win_i_i;
      win_q_q <= win_q_i;
      acc_i_q <= acc_i_d;
      acc_q_q <= acc_q_d;
    end
  end

  assign valid_o = valid_q;
  assign win_i_o = win_i_q;
  assign win_q_o = win_q_q;
  assign acc_i_o = acc_i_q;
  assign acc_q_o = acc_q_q;

endmodule

[hw/rtl/ipsf_round_sat.sv]
// Output stage: rounds both sums to Q1.15 (half toward +inf), saturates,
// and holds the result request until it is taken.
// Depends on ipsf_pkg.
module ipsf_round_sat #(
  parameter int unsigned ACC_W = 35
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic                    valid_i,
  input  logic signed [ACC_W-1:0] acc_i_i,
  input  logic signed [ACC_W-1:0] acc_q_i,
  output logic                    valid_o,
  output ipsf_pkg::sample_t       out_i_o,
  output ipsf_pkg::sample_t       out_q_o,
  output logic                    sat_o
);
  import ipsf_pkg::*;

  localparam int unsigned RW = ACC_W + 1 - FRAC_W;
  localparam logic signed [ACC_W:0]  HALF = (ACC_W + 1)'(1 << (FRAC_W - 1));
  localparam logic signed [RW-1:0]   RMAX = RW'(32767);
  localparam logic signed [RW-1:0]   RMIN = RW'(-32768);

  logic signed [ACC_W:0]  sum_i, sum_q;
  logic signed [RW-1:0]   r_i, r_q;
  logic                   hi_i, lo_i, hi_q, lo_q;
  sample_t                res_i_d, res_q_d;
  sample_t                res_i_q, res_q_q;
  logic                   sat_d, sat_q, valid_q;

  always_comb begin
    sum_i   = {acc_i_i[ACC_W-1], acc_i_i} + HALF;
    sum_q   = {acc_q_i[ACC_W-1], acc_q_i} + HALF;
    r_i     = sum_i[ACC_W:FRAC_W];
    r_q     = sum_q[ACC_W:FRAC_W];
    hi_i    = r_i > RMAX;
    lo_i    = r_i < RMIN;
    hi_q    = r_q > RMAX;
    lo_q    = r_q < RMIN;
    res_i_d = hi_i ? SAMPLE_MAX : (lo_i ? SAMPLE_MIN : r_i[SAMPLE_W-1:0]);
    res_q_d = hi_q ? SAMPLE_MAX : (lo_q ? SAMPLE_MIN : r_q[SAMPLE_W-1:0]);
    sat_d   = hi_i | lo_i | hi_q | lo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_i_q <= res_i_d;
      res_q_q <= res_q_d;
      sat_q   <= sat_d;
    end
  end

  assign valid_o = valid_q;
  assign out_i_o = res_i_q;
  assign out_q_o = res_q_q;
  assign sat_o   = sat_q;

endmodule

[hw/rtl/ipsf_checker.sv]
// Port-level checks for iq_pulse_shaping_fir_core, bound to the top level.
// Depends on ipsf_pkg.
module ipsf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ipsf_pkg::sample_t out_i_o,
  input ipsf_pkg::sample_t out_q_o,
  input logic              saturated_o
);
  import ipsf_pkg::*;

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (out_i_o == SAMPLE_MAX || out_i_o == SAMPLE_MIN ||
       out_q_o == SAMPLE_MAX || out_q_o == SAMPLE_MIN))
    else $error("saturation flag without clipped output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_i_o) && $stable(out_q_o) && $stable(saturated_o)))
    else $error("stalled result changed");

endmodule

bind iq_pulse_shaping_fir_core ipsf_checker u_ipsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_i_o     (out_i_o),
  .out_q_o     (out_q_o),
  .saturated_o (saturated_o)
);
